// ----- hdl/ltm_pkg.sv -----
// ----------------------------------------------------------------------------
// ltm_pkg: shared types, constants and glyph tables
// Transaction types, arithmetic constants and font tables of the lap time
// matrix renderer.
// ----------------------------------------------------------------------------
package ltm_pkg;

    localparam int MODULES = 4;
    localparam int COLS    = MODULES * 8;
    localparam int ROWS    = 8;
    localparam int ROW_W   = $clog2(ROWS);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [31:0] READY_TICKS   = 32'd36000000;
    localparam logic [31:0] DIV100_MUL    = 32'h51EB851F;
    localparam int          DIV100_SHIFT  = 37;
    localparam logic [15:0] DIV60_MUL     = 16'd34953;
    localparam int          DIV60_SHIFT   = 21;
    localparam logic [7:0]  DIV10_MUL     = 8'd205;
    localparam int          DIV10_SHIFT   = 11;
    localparam logic [6:0]  CENTI_PER_SEC = 7'd100;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [3:0]  RADIX         = 4'd10;

    localparam logic [7:0]  SEP_DOT       = 8'h40;
    localparam logic [7:0]  SEP_COLON     = 8'h24;
    localparam int          SEP_COL       = 18;
    localparam int          READY_COL     = 1;
    localparam int          READY_PITCH   = 6;
    localparam int          DIGIT_COL0    = 6;
    localparam int          DIGIT_COL1    = 12;
    localparam int          DIGIT_COL2    = 20;
    localparam int          DIGIT_COL3    = 26;

    typedef struct packed {
        logic [7:0]  lap_count;
        logic [31:0] tick_count;
    } ltm_in_t;

    typedef struct packed {
        logic [3:0] row_address;
        logic [7:0] module0_row;
        logic [7:0] module1_row;
        logic [7:0] module2_row;
        logic [7:0] module3_row;
        logic       showing_ready;
        logic       last_row;
    } ltm_out_t;

    typedef struct packed {
        logic       show_ready;
        logic       colon;
        logic [3:0] lap_digit;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
        logic [3:0] d4;
    } ltm_glyph_t;

    typedef logic [COLS-1:0][7:0] ltm_cols_t;

    function automatic logic [39:0] digit_glyph(logic [3:0] d);
        logic [39:0] g;
        case (d)
            4'd0:    g = 40'h3E_51_49_45_3E;
            4'd1:    g = 40'h00_42_7F_40_00;
            4'd2:    g = 40'h42_61_51_49_46;
            4'd3:    g = 40'h21_41_45_4B_31;
            4'd4:    g = 40'h18_14_12_7F_10;
            4'd5:    g = 40'h27_45_45_45_39;
            4'd6:    g = 40'h3C_4A_49_49_30;
            4'd7:    g = 40'h01_71_09_05_03;
            4'd8:    g = 40'h36_49_49_49_36;
            4'd9:    g = 40'h06_49_49_29_1E;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [23:0] tiny_glyph(logic [3:0] d);
        logic [23:0] g;
        case (d)
            4'd0:    g = 24'h1F_11_1F;
            4'd1:    g = 24'h00_1F_00;
            4'd2:    g = 24'h1D_15_17;
            4'd3:    g = 24'h15_15_1F;
            4'd4:    g = 24'h07_04_1F;
            4'd5:    g = 24'h17_15_1D;
            4'd6:    g = 24'h1F_15_1D;
            4'd7:    g = 24'h01_01_1F;
            4'd8:    g = 24'h1F_15_1F;
            4'd9:    g = 24'h17_15_1F;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [39:0] ready_glyph(logic [2:0] k);
        logic [39:0] g;
        case (k)
            3'd0:    g = 40'h7F_09_19_29_46;
            3'd1:    g = 40'h7F_49_49_49_41;
            3'd2:    g = 40'h7C_12_11_12_7C;
            3'd3:    g = 40'h7F_41_41_22_1C;
            3'd4:    g = 40'h07_08_70_08_07;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic ltm_cols_t render_cols(ltm_glyph_t g);
        ltm_cols_t   cols;
        logic [39:0] gl;
        logic [23:0] tl;
        logic [39:0] g1;
        logic [39:0] g2;
        logic [39:0] g3;
        logic [39:0] g4;
        cols = '0;
        if (g.show_ready)
        begin
            for (int k = 0; k < 5; k++)
            begin
                gl = ready_glyph(3'(k));
                for (int i = 0; i < 5; i++)
                begin
                    cols[READY_COL + READY_PITCH * k + i] = gl[39 - 8 * i -: 8];
                end
            end
        end
        else
        begin
            tl = tiny_glyph(g.lap_digit);
            g1 = digit_glyph(g.d1);
            g2 = digit_glyph(g.d2);
            g3 = digit_glyph(g.d3);
            g4 = digit_glyph(g.d4);
            for (int i = 0; i < 3; i++)
            begin
                cols[i] = tl[23 - 8 * i -: 8];
            end
            for (int i = 0; i < 5; i++)
            begin
                cols[DIGIT_COL0 + i] = g1[39 - 8 * i -: 8];
                cols[DIGIT_COL1 + i] = g2[39 - 8 * i -: 8];
                cols[DIGIT_COL2 + i] = g3[39 - 8 * i -: 8];
                cols[DIGIT_COL3 + i] = g4[39 - 8 * i -: 8];
            end
            cols[SEP_COL] = g.colon ? SEP_COLON : SEP_DOT;
        end
        return cols;
    endfunction

endpackage

// ----- hdl/ltm_front.sv -----
// ----------------------------------------------------------------------------
// ltm_front: time classification pipeline
// Splits the tick count into display digits over seven stages and keeps a
// credit count so that the glyph queue can never overflow.
// ----------------------------------------------------------------------------
module ltm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ltm_pkg::ltm_in_t   item,
    input  logic               q_taken,
    output logic               wr_en,
    output ltm_pkg::ltm_glyph_t wr_data
);

    logic [6:0]                vld_reg, vld_next;
    logic [ltm_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                      accept;

    logic [7:0]  lap1_reg, lap1_next;
    logic [25:0] tick1_reg, tick1_next;
    logic        rdy1_reg, rdy1_next;

    logic [7:0]  lap2_reg, lap2_next;
    logic [4:0]  lapq2_reg, lapq2_next;
    logic [18:0] centi2_reg, centi2_next;
    logic        rdy2_reg, rdy2_next;

    logic [3:0]  lapd3_reg, lapd3_next;
    logic [18:0] centi3_reg, centi3_next;
    logic [11:0] secs3_reg, secs3_next;
    logic        rdy3_reg, rdy3_next;

    logic [3:0]  lapd4_reg, lapd4_next;
    logic [6:0]  hund4_reg, hund4_next;
    logic [11:0] secs4_reg, secs4_next;
    logic [5:0]  mins4_reg, mins4_next;
    logic        rdy4_reg, rdy4_next;

    logic [3:0]  lapd5_reg, lapd5_next;
    logic [6:0]  hund5_reg, hund5_next;
    logic [5:0]  secs5_reg, secs5_next;
    logic [5:0]  mins5_reg, mins5_next;
    logic [5:0]  srem5_reg, srem5_next;
    logic        colon5_reg, colon5_next;
    logic        rdy5_reg, rdy5_next;

    logic [3:0]  lapd6_reg, lapd6_next;
    logic [5:0]  a6_reg, a6_next;
    logic [6:0]  b6_reg, b6_next;
    logic [2:0]  qa6_reg, qa6_next;
    logic [3:0]  qb6_reg, qb6_next;
    logic        colon6_reg, colon6_next;
    logic        rdy6_reg, rdy6_next;

    ltm_pkg::ltm_glyph_t g7_reg, g7_next;

    logic [57:0] centi_prod;
    logic [50:0] secs_prod;
    logic [15:0] lapq_prod;
    logic [27:0] mins_prod;
    logic [13:0] qa_prod;
    logic [14:0] qb_prod;
    logic [7:0]  lapd_diff;
    logic [18:0] hund_diff;
    logic [11:0] srem_diff;
    logic [7:0]  d2_diff;
    logic [7:0]  d4_diff;

    assign accept = push && !full;
    assign full   = (cnt_reg == ltm_pkg::QCNT_W'(ltm_pkg::QDEPTH));
    assign wr_en  = vld_reg[6];
    assign wr_data = g7_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !q_taken)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && q_taken)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        vld_next = {vld_reg[5:0], accept};
    end

    always_comb
    begin
        lap1_next  = item.lap_count;
        tick1_next = item.tick_count[25:0];
        rdy1_next  = item.tick_count >= ltm_pkg::READY_TICKS;

        centi_prod  = 58'(tick1_reg) * 58'(ltm_pkg::DIV100_MUL);
        lapq_prod   = 16'(lap1_reg) * 16'(ltm_pkg::DIV10_MUL);
        lap2_next   = lap1_reg;
        lapq2_next  = lapq_prod[ltm_pkg::DIV10_SHIFT +: 5];
        centi2_next = centi_prod[ltm_pkg::DIV100_SHIFT +: 19];
        rdy2_next   = rdy1_reg;

        secs_prod   = 51'(centi2_reg) * 51'(ltm_pkg::DIV100_MUL);
        lapd_diff   = lap2_reg - 8'(lapq2_reg) * 8'(ltm_pkg::RADIX);
        lapd3_next  = lapd_diff[3:0];
        centi3_next = centi2_reg;
        secs3_next  = secs_prod[ltm_pkg::DIV100_SHIFT +: 12];
        rdy3_next   = rdy2_reg;

        mins_prod  = 28'(secs3_reg) * 28'(ltm_pkg::DIV60_MUL);
        hund_diff  = centi3_reg - 19'(secs3_reg) * 19'(ltm_pkg::CENTI_PER_SEC);
        lapd4_next = lapd3_reg;
        hund4_next = hund_diff[6:0];
        secs4_next = secs3_reg;
        mins4_next = mins_prod[ltm_pkg::DIV60_SHIFT +: 6];
        rdy4_next  = rdy3_reg;

        srem_diff   = secs4_reg - 12'(mins4_reg) * 12'(ltm_pkg::SECS_PER_MIN);
        lapd5_next  = lapd4_reg;
        hund5_next  = hund4_reg;
        secs5_next  = secs4_reg[5:0];
        mins5_next  = mins4_reg;
        srem5_next  = srem_diff[5:0];
        colon5_next = secs4_reg >= 12'(ltm_pkg::SECS_PER_MIN);
        rdy5_next   = rdy4_reg;

        a6_next     = colon5_reg ? mins5_reg : secs5_reg;
        b6_next     = colon5_reg ? {1'b0, srem5_reg} : hund5_reg;
        qa_prod     = 14'(a6_next) * 14'(ltm_pkg::DIV10_MUL);
        qb_prod     = 15'(b6_next) * 15'(ltm_pkg::DIV10_MUL);
        qa6_next    = qa_prod[ltm_pkg::DIV10_SHIFT +: 3];
        qb6_next    = qb_prod[ltm_pkg::DIV10_SHIFT +: 4];
        lapd6_next  = lapd5_reg;
        colon6_next = colon5_reg;
        rdy6_next   = rdy5_reg;

        d2_diff = 8'(a6_reg) - 8'(qa6_reg) * 8'(ltm_pkg::RADIX);
        d4_diff = 8'(b6_reg) - 8'(qb6_reg) * 8'(ltm_pkg::RADIX);
        g7_next.show_ready = rdy6_reg;
        g7_next.colon      = colon6_reg;
        g7_next.lap_digit  = lapd6_reg;
        g7_next.d1         = 4'(qa6_reg);
        g7_next.d2         = d2_diff[3:0];
        g7_next.d3         = qb6_reg;
        g7_next.d4         = d4_diff[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lap1_reg    <= lap1_next;
        tick1_reg   <= tick1_next;
        rdy1_reg    <= rdy1_next;
        lap2_reg    <= lap2_next;
        lapq2_reg   <= lapq2_next;
        centi2_reg  <= centi2_next;
        rdy2_reg    <= rdy2_next;
        lapd3_reg   <= lapd3_next;
        centi3_reg  <= centi3_next;
        secs3_reg   <= secs3_next;
        rdy3_reg    <= rdy3_next;
        lapd4_reg   <= lapd4_next;
        hund4_reg   <= hund4_next;
        secs4_reg   <= secs4_next;
        mins4_reg   <= mins4_next;
        rdy4_reg    <= rdy4_next;
        lapd5_reg   <= lapd5_next;
        hund5_reg   <= hund5_next;
        secs5_reg   <= secs5_next;
        mins5_reg   <= mins5_next;
        srem5_reg   <= srem5_next;
        colon5_reg  <= colon5_next;
        rdy5_reg    <= rdy5_next;
        lapd6_reg   <= lapd6_next;
        a6_reg      <= a6_next;
        b6_reg      <= b6_next;
        qa6_reg     <= qa6_next;
        qb6_reg     <= qb6_next;
        colon6_reg  <= colon6_next;
        rdy6_reg    <= rdy6_next;
        g7_reg      <= g7_next;
    end

`ifndef SYNTHESIS
    a_credit_never_underflows: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_taken |-> (cnt_reg != '0)
    ) else $error("ltm_front: queue read without an outstanding credit");

    a_credit_covers_pipeline: assert property (
        @(posedge clk) disable iff (!rst_n)
        32'($countones(vld_reg)) <= 32'(cnt_reg)
    ) else $error("ltm_front: more items in flight than credits taken");
`endif

endmodule

// ----- hdl/ltm_queue.sv -----
// ----------------------------------------------------------------------------
// ltm_queue: glyph queue
// Short first-in first-out buffer between the classification pipeline and
// the row emitter.
// ----------------------------------------------------------------------------
module ltm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ltm_pkg::ltm_glyph_t wr_data,
    input  logic                rd_en,
    output logic                rd_valid,
    output ltm_pkg::ltm_glyph_t rd_data
);

    ltm_pkg::ltm_glyph_t         mem_reg [ltm_pkg::QDEPTH];
    logic [ltm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ltm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ltm_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/ltm_back.sv -----
// ----------------------------------------------------------------------------
// ltm_back: bitmap render and row emitter
// Renders one queued glyph set into a column bitmap and presents it as eight
// row transactions, one per cycle while pop is held.
// ----------------------------------------------------------------------------
module ltm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ltm_pkg::ltm_glyph_t q_data,
    output logic                q_read,
    output logic                empty,
    input  logic                pop,
    output ltm_pkg::ltm_out_t   result
);

    ltm_pkg::ltm_cols_t          cols_reg, cols_next;
    logic                        busy_reg, busy_next;
    logic                        ready_reg, ready_next;
    logic [ltm_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                        take;
    logic                        done;
    logic                        load;
    logic [ltm_pkg::MODULES-1:0][7:0] rows;

    assign empty = !busy_reg;
    assign take  = pop && busy_reg;
    assign done  = take && (row_reg == ltm_pkg::ROW_W'(ltm_pkg::ROWS - 1));
    assign load  = q_valid && (!busy_reg || done);
    assign q_read = load;

    always_comb
    begin
        busy_next  = busy_reg;
        row_next   = row_reg;
        cols_next  = cols_reg;
        ready_next = ready_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            row_next   = '0;
            cols_next  = ltm_pkg::render_cols(q_data);
            ready_next = q_data.show_ready;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            row_next = row_reg + 1'b1;
        end
    end

    always_comb
    begin
        for (int m = 0; m < ltm_pkg::MODULES; m++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                rows[m][7 - c] = cols_reg[8 * m + c][row_reg];
            end
        end
        result.row_address   = 4'(row_reg) + 4'd1;
        result.module0_row   = rows[0];
        result.module1_row   = rows[1];
        result.module2_row   = rows[2];
        result.module3_row   = rows[3];
        result.showing_ready = ready_reg;
        result.last_row      = (row_reg == ltm_pkg::ROW_W'(ltm_pkg::ROWS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cols_reg  <= cols_next;
        ready_reg <= ready_next;
    end

`ifndef SYNTHESIS
    a_row_advances: assert property (
        @(posedge clk) disable iff (!rst_n)
        (take && !done) |=> (busy_reg && row_reg == $past(row_reg) + 1'b1)
    ) else $error("ltm_back: row did not advance after a row transaction");

    a_idle_loads: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_valid && !busy_reg) |-> q_read
    ) else $error("ltm_back: queued glyphs left waiting while idle");

    a_drain_to_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !q_valid) |=> empty
    ) else $error("ltm_back: still busy after the last row with nothing queued");

    a_load_starts_row0: assert property (
        @(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && row_reg == '0)
    ) else $error("ltm_back: new bitmap did not start at the first row");
`endif

endmodule

// ----- hdl/lap_time_matrix_renderer.sv -----
// The first row transaction is offered once an accepted item has passed the
// digit pipeline, the glyph queue and the bitmap register, if the row emitter
// is idle; it sends one row word per cycle while pop is held.
// The seven-stage digit pipeline takes a new item every cycle unless full.
// Reset (rst_n low, asynchronous): pipeline, queue and emitter are emptied,
// empty reads high and full reads low.
// ----------------------------------------------------------------------------
// lap_time_matrix_renderer: lap time display renderer
// Turns a lap count and a tick count into eight row words for four 8x8 LED
// modules.
// ----------------------------------------------------------------------------
module lap_time_matrix_renderer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ltm_pkg::ltm_in_t  item,
    output logic              empty,
    input  logic              pop,
    output ltm_pkg::ltm_out_t result
);

    logic                wr_en;
    ltm_pkg::ltm_glyph_t wr_data;
    logic                q_valid;
    logic                q_read;
    ltm_pkg::ltm_glyph_t q_data;

    ltm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_taken (q_read),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    ltm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .rd_en    (q_read),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    ltm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_read  (q_read),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
